// File: hdl/ewp_pkg.sv
// shared types, constants and register codes for the waveform playback unit
package ewp_pkg;

   // waveform table geometry (depth is a power of two, 65536 words)
   localparam int TABLE_AW    = 16;
   localparam int TABLE_DEPTH = 1 << TABLE_AW;
   localparam int WORD_W      = 16;

   // one group is eight rows, one table word holds eight 2-bit sub-phase codes
   localparam int ROWS   = 8;
   localparam int ROW_W  = $clog2(ROWS);
   localparam int SUBS   = 8;
   localparam int SUB_W  = $clog2(SUBS);
   localparam int CODE_W = 2;

   // field widths
   localparam int TRANS_W  = 12;
   localparam int MW_W     = 7;
   localparam int PHASE_W  = 8;
   localparam int NUM_W    = 4;
   localparam int TOP_W    = 12;
   localparam int CSR_W    = 12;
   localparam int WIDX_W   = PHASE_W - SUB_W;
   localparam int SQ_W     = 2 * MW_W;
   localparam int SUM_W    = 20;
   localparam int OFFSET_W = 23;

   // destination offset constants
   localparam int COL_SHIFT  = 3;
   localparam int XRES_WORDS = 'h104;
   localparam int ROW_BIAS   = 'h1a;

   // register reset values
   localparam logic [MW_W-1:0]    MW_RESET    = 7'd32;
   localparam logic [PHASE_W-1:0] PHASE_RESET = 8'd0;
   localparam logic [NUM_W-1:0]   FC_RESET    = 4'd1;
   localparam logic [TOP_W-1:0]   TOP_RESET   = 12'd0;

   typedef enum logic [1:0] {
      CSR_ROW_WIDTH = 2'd0,
      CSR_PHASE     = 2'd1,
      CSR_BURST_LEN = 2'd2,
      CSR_RECT_TOP  = 2'd3
   } csr_index_type;

   typedef enum logic {
      CMD_PLAY  = 1'b0,
      CMD_WRITE = 1'b1
   } cmd_type;

   typedef logic [TABLE_AW-1:0]            addr_type;
   typedef logic [SUM_W-1:0]               sum_type;
   typedef logic [WORD_W-1:0]              word_type;
   typedef logic [ROW_W-1:0]               row_type;
   typedef logic [SUB_W-1:0]               sub_idx_type;
   typedef logic [NUM_W-1:0]               num_type;
   typedef logic [SQ_W-1:0]                sq_type;
   typedef logic [OFFSET_W-1:0]            offset_type;
   typedef logic [OFFSET_W-3:0]            off_words_type;
   typedef logic [ROWS-1:0][TRANS_W-1:0]   trans_type;
   typedef logic [SUBS-1:0][WORD_W-1:0]    sub_type;

   typedef struct packed {
      cmd_type      cmd;
      logic [11:0]  column;
      logic [8:0]   group_index;
      logic [15:0]  table_address;
      logic [15:0]  table_word;
      logic [47:0]  rows_upper;
      logic [47:0]  rows_lower;
   } req_type;

   typedef struct packed {
      logic [2:0]   frame_slot;
      logic [22:0]  byte_offset;
      logic [15:0]  drive_bits;
      logic         last;
   } rsp_type;

   typedef struct packed {
      logic [MW_W-1:0]    row_width;
      logic [PHASE_W-1:0] phase;
      logic [NUM_W-1:0]   burst_len;
      logic [TOP_W-1:0]   rect_top;
   } cfg_type;

   // per-group data that rides along with the table reads
   typedef struct packed {
      offset_type  offset;
      sub_idx_type first;
      num_type     num;
   } meta_type;

   // one transaction after the address and offset stages
   typedef struct packed {
      cmd_type                 cmd;
      addr_type                wr_addr;
      word_type                wr_word;
      trans_type               trans;
      sq_type                  sq;
      logic [WIDX_W-1:0]       widx;
      meta_type                meta;
   } job_type;

   // one fully gathered and transposed group
   typedef struct packed {
      sub_type  sub;
      meta_type meta;
   } grp_type;

endpackage

// File: hdl/ewp_ram.sv
// generic single write, single registered read memory
module ewp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/ewp_front.sv
// input register and address/offset stages of the waveform playback unit
module ewp_front (
   input  logic             clock,
   input  logic             reset,
   input  ewp_pkg::cfg_type cfg,
   input  logic             req_valid,
   output logic             req_ready,
   input  ewp_pkg::req_type req_data,
   output logic             job_vld,
   input  logic             job_rdy,
   output ewp_pkg::job_type job
);

   logic             s1_vld_ff;
   ewp_pkg::req_type s1_ff;
   logic             s2_vld_ff;
   ewp_pkg::job_type s2_ff;
   ewp_pkg::job_type s2_in;
   logic             s2_free;

   ewp_pkg::off_words_type col_sum;
   ewp_pkg::off_words_type off_words;
   ewp_pkg::num_type       avail;
   ewp_pkg::sub_idx_type   first;

   // stage flow control
   assign s2_free   = !s2_vld_ff || job_rdy;
   assign req_ready = !s1_vld_ff || s2_free;

   // second stage contents: square of the row width, offset, frame count
   always_comb begin
      first   = cfg.phase[ewp_pkg::SUB_W-1:0];
      avail   = ewp_pkg::num_type'(ewp_pkg::SUBS) - ewp_pkg::num_type'(first);
      col_sum = ewp_pkg::off_words_type'(s1_ff.column)
              + ewp_pkg::off_words_type'(ewp_pkg::COL_SHIFT);
      off_words = col_sum * ewp_pkg::off_words_type'(ewp_pkg::XRES_WORDS)
                + ewp_pkg::off_words_type'(cfg.rect_top >> ewp_pkg::ROW_W)
                + ewp_pkg::off_words_type'(s1_ff.group_index)
                + ewp_pkg::off_words_type'(ewp_pkg::ROW_BIAS);

      s2_in.cmd        = s1_ff.cmd;
      s2_in.wr_addr    = ewp_pkg::addr_type'(ewp_pkg::sum_type'(s1_ff.table_address));
      s2_in.wr_word    = s1_ff.table_word;
      s2_in.trans      = {s1_ff.rows_lower, s1_ff.rows_upper};
      s2_in.sq         = ewp_pkg::sq_type'(cfg.row_width)
                       * ewp_pkg::sq_type'(cfg.row_width);
      s2_in.widx       = cfg.phase[ewp_pkg::PHASE_W-1:ewp_pkg::SUB_W];
      s2_in.meta.offset = ewp_pkg::offset_type'({off_words, 2'b00});
      s2_in.meta.first = first;
      s2_in.meta.num   = (cfg.burst_len < avail) ? cfg.burst_len : avail;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            s1_vld_ff <= req_valid;
         end
         if (s2_free) begin
            s2_vld_ff <= s1_vld_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_ff <= req_data;
      end
      if (s2_free && s1_vld_ff) begin
         s2_ff <= s2_in;
      end
   end

   assign job_vld = s2_vld_ff;
   assign job     = s2_ff;

endmodule

// File: hdl/ewp_lookup.sv
// table read sequencer, gather buffer and transpose of the waveform playback unit
module ewp_lookup (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_vld,
   output logic             job_rdy,
   input  ewp_pkg::job_type job,
   output logic             grp_vld,
   input  logic             grp_rdy,
   output ewp_pkg::grp_type grp
);

   logic                busy_ff;
   ewp_pkg::row_type    row_ff;
   ewp_pkg::sum_type    base_ff;
   ewp_pkg::trans_type  trans_ff;
   ewp_pkg::meta_type   meta_ff;

   logic                cap_vld_ff;
   ewp_pkg::row_type    cap_row_ff;
   ewp_pkg::meta_type   cap_meta_ff;
   ewp_pkg::word_type   words_ff [ewp_pkg::ROWS-1];

   ewp_pkg::word_type   rows_all [ewp_pkg::ROWS];
   ewp_pkg::word_type   rd_data;
   ewp_pkg::addr_type   rd_addr;
   logic                freeze;
   logic                issue;
   logic                row_last;
   logic                job_take;
   logic                play_load;
   logic                wr_en;

   // the read pipe holds while a finished group waits for the emitter
   assign freeze    = grp_vld && !grp_rdy;
   assign issue     = busy_ff && !freeze;
   assign row_last  = (row_ff == ewp_pkg::row_type'(ewp_pkg::ROWS - 1));
   assign job_rdy   = !busy_ff || (row_last && !freeze);
   assign job_take  = job_vld && job_rdy;
   assign play_load = job_take && (job.cmd == ewp_pkg::CMD_PLAY) && (job.meta.num != '0);
   assign wr_en     = job_take && (job.cmd == ewp_pkg::CMD_WRITE);

   // row address, wrapping at the table depth
   assign rd_addr = ewp_pkg::addr_type'(base_ff + ewp_pkg::sum_type'(trans_ff[row_ff]));

   ewp_ram #(
      .WIDTH (ewp_pkg::WORD_W),
      .DEPTH (ewp_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (job.wr_addr),
      .wr_data (job.wr_word),
      .rd_en   (issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // sequencer control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         row_ff  <= '0;
      end else begin
         if (issue) begin
            if (row_last) begin
               busy_ff <= 1'b0;
            end else begin
               row_ff <= row_ff + ewp_pkg::row_type'(1);
            end
         end
         if (play_load) begin
            busy_ff <= 1'b1;
            row_ff  <= '0;
         end
      end
   end

   // group data for the reads, base is a 14 by 5 bit product
   always_ff @(posedge clock) begin
      if (play_load) begin
         base_ff  <= ewp_pkg::sum_type'(job.sq) * ewp_pkg::sum_type'(job.widx)
                   + ewp_pkg::sum_type'(job.widx);
         trans_ff <= job.trans;
         meta_ff  <= job.meta;
      end
   end

   // capture tag follows the read data
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_vld_ff <= 1'b0;
      end else if (!freeze) begin
         cap_vld_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (!freeze) begin
         cap_row_ff  <= row_ff;
         cap_meta_ff <= meta_ff;
      end
      if (cap_vld_ff && !freeze && (cap_row_ff != ewp_pkg::row_type'(ewp_pkg::ROWS - 1))) begin
         words_ff[cap_row_ff] <= rd_data;
      end
   end

   // last row comes straight from the memory output
   assign grp_vld = cap_vld_ff && (cap_row_ff == ewp_pkg::row_type'(ewp_pkg::ROWS - 1));

   // transpose: row r of sub-phase b lands at the top for row 0
   always_comb begin
      for (int r = 0; r < ewp_pkg::ROWS - 1; r++) begin
         rows_all[r] = words_ff[r];
      end
      rows_all[ewp_pkg::ROWS-1] = rd_data;
      grp.sub = '0;
      for (int b = 0; b < ewp_pkg::SUBS; b++) begin
         for (int r = 0; r < ewp_pkg::ROWS; r++) begin
            grp.sub[b][(ewp_pkg::ROWS-1-r)*ewp_pkg::CODE_W +: ewp_pkg::CODE_W] =
               rows_all[r][b*ewp_pkg::CODE_W +: ewp_pkg::CODE_W];
         end
      end
      grp.meta = cap_meta_ff;
   end

endmodule

// File: hdl/ewp_emit.sv
// frame word emitter and result register of the waveform playback unit
module ewp_emit (
   input  logic             clock,
   input  logic             reset,
   input  logic             grp_vld,
   output logic             grp_rdy,
   input  ewp_pkg::grp_type grp,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ewp_pkg::rsp_type rsp_data
);

   logic                 em_vld_ff;
   ewp_pkg::grp_type     em_ff;
   ewp_pkg::sub_idx_type em_k_ff;
   logic                 rsp_vld_ff;
   ewp_pkg::rsp_type     rsp_ff;
   ewp_pkg::rsp_type     rsp_in;
   ewp_pkg::sub_idx_type sel;
   logic                 out_load;
   logic                 em_last;

   // one frame word per cycle into the result register while it is empty or being taken
   assign out_load = em_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign em_last  = ((ewp_pkg::num_type'(em_k_ff) + ewp_pkg::num_type'(1)) == em_ff.meta.num);
   assign grp_rdy  = !em_vld_ff || (out_load && em_last);
   assign sel      = em_ff.meta.first + em_k_ff;

   always_comb begin
      rsp_in.frame_slot  = em_k_ff;
      rsp_in.byte_offset = em_ff.meta.offset;
      rsp_in.drive_bits  = em_ff.sub[sel];
      rsp_in.last        = em_last;
   end

   // emitter and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         em_vld_ff  <= 1'b0;
         em_k_ff    <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (grp_vld && grp_rdy) begin
            em_vld_ff <= 1'b1;
            em_k_ff   <= '0;
         end else if (out_load) begin
            if (em_last) begin
               em_vld_ff <= 1'b0;
            end else begin
               em_k_ff <= em_k_ff + ewp_pkg::sub_idx_type'(1);
            end
         end
         if (out_load) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // group and result payload
   always_ff @(posedge clock) begin
      if (grp_vld && grp_rdy) begin
         em_ff <= grp;
      end
      if (out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: hdl/epaper_waveform_playback_unit.sv
// top level of the e-paper waveform playback unit
//
//   port group  direction  handshake             transaction
//   req_*       in         req_valid/req_ready   table write or one 8-row group
//   rsp_*       out        rsp_valid/rsp_ready   one frame word with offset and slot
//   csr_*       in         csr_write_en          one register write, no read-back
//
// a group's eight row words are fetched from the table memory, which has one read
// port, one per cycle while the read pipe is not held; groups follow back to back,
// and table writes go in at one per cycle while no group is being read.
// reset clears all valid bits and the configuration registers; the payload registers and the table are not cleared.
// a stalled result register holds the emitter, which in turn holds the read
// pipe and the input stages; nothing is dropped or repeated.
module epaper_waveform_playback_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ewp_pkg::req_type       req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ewp_pkg::rsp_type       rsp_data,
   input  logic                   csr_write_en,
   input  ewp_pkg::csr_index_type csr_index,
   input  logic [ewp_pkg::CSR_W-1:0] csr_wdata
);

   ewp_pkg::cfg_type cfg_ff;
   logic             job_vld;
   logic             job_rdy;
   ewp_pkg::job_type job;
   logic             grp_vld;
   logic             grp_rdy;
   ewp_pkg::grp_type grp;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_width <= ewp_pkg::MW_RESET;
         cfg_ff.phase     <= ewp_pkg::PHASE_RESET;
         cfg_ff.burst_len <= ewp_pkg::FC_RESET;
         cfg_ff.rect_top  <= ewp_pkg::TOP_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            ewp_pkg::CSR_ROW_WIDTH: begin
               cfg_ff.row_width <= csr_wdata[ewp_pkg::MW_W-1:0];
            end
            ewp_pkg::CSR_PHASE: begin
               cfg_ff.phase <= csr_wdata[ewp_pkg::PHASE_W-1:0];
            end
            ewp_pkg::CSR_BURST_LEN: begin
               cfg_ff.burst_len <= csr_wdata[ewp_pkg::NUM_W-1:0];
            end
            ewp_pkg::CSR_RECT_TOP: begin
               cfg_ff.rect_top <= csr_wdata[ewp_pkg::TOP_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   ewp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .job_vld   (job_vld),
      .job_rdy   (job_rdy),
      .job       (job)
   );

   ewp_lookup u_lookup (
      .clock   (clock),
      .reset   (reset),
      .job_vld (job_vld),
      .job_rdy (job_rdy),
      .job     (job),
      .grp_vld (grp_vld),
      .grp_rdy (grp_rdy),
      .grp     (grp)
   );

   ewp_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .grp_vld   (grp_vld),
      .grp_rdy   (grp_rdy),
      .grp       (grp),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   // a waiting group keeps its gathered words while the read pipe is held
   a_grp_hold: assert property (@(posedge clock) disable iff (reset)
      grp_vld && !grp_rdy |=> grp_vld && $stable(grp))
      else $error("gathered group changed while held");

   // frame words of one group come without gaps, same offset, next slot
   a_grp_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last |=> rsp_valid
         && (rsp_data.frame_slot == $past(rsp_data.frame_slot) + 3'd1)
         && (rsp_data.byte_offset == $past(rsp_data.byte_offset)))
      else $error("frame words of a group not contiguous");

   // a new group always starts at frame slot zero
   a_grp_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.last |=> !rsp_valid
         || (rsp_data.frame_slot == 3'd0))
      else $error("group does not start at slot zero");

   // a waiting result keeps its payload until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while waiting");
`endif

endmodule
